[rtl/modular_exponentiation_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation block
// Clocked on clk, quiet while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication
`define MEXP_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MEXP_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/mexp_pkg.sv]
// ---------------------------------------------------------------------------
// mexp_pkg
// Widths, register indexes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package mexp_pkg;

	localparam int EXP_BITS   = 31;
	localparam int MOD_BITS   = 31;
	localparam int BYTE_BITS  = 8;
	localparam int EBIT_W     = $clog2(EXP_BITS);
	localparam int CNT_W      = $clog2(MOD_BITS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = (EXP_BITS > MOD_BITS) ? EXP_BITS : MOD_BITS;
	localparam int OUT_BYTES  = (MOD_BITS + 7) / 8;
	localparam int OUT_W      = OUT_BYTES * 8;

	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

	typedef struct packed {
		logic load;       // take a new byte and start its reduction
		logic start_sqr;  // acc = acc * acc mod m
		logic start_mul;  // acc = acc * base mod m
		logic emit;       // move acc into the output register
	} mexp_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_status_t;

endpackage

[rtl/mexp_datapath.sv]
// ---------------------------------------------------------------------------
// mexp_datapath
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle,
// with the base, accumulator and result registers around it.
// ---------------------------------------------------------------------------
module mexp_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mexp_pkg::mexp_cmd_t          cmd,
	output mexp_pkg::mexp_status_t       status,
	input  logic [mexp_pkg::BYTE_BITS-1:0] in_byte,
	input  logic [mexp_pkg::MOD_BITS-1:0]  modulus,
	output logic [mexp_pkg::MOD_BITS-1:0]  result
);
	import mexp_pkg::*;

	localparam int SUM_W = MOD_BITS + 2;

	logic [MOD_BITS-1:0] base_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] mul_a_q;
	logic [MOD_BITS-1:0] mul_b_q;
	logic [MOD_BITS-1:0] prod_q;
	logic [MOD_BITS-1:0] res_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic                to_base_q;

	logic [MOD_BITS-1:0] one_mod;
	logic [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]    mod_1x;
	logic [SUM_W-1:0]    mod_2x;
	logic [SUM_W-1:0]    step;
	logic [MOD_BITS-1:0] next_prod;
	logic                last_bit;

	// 1 mod m: zero when the modulus is one
	assign one_mod = MOD_BITS'(modulus != MOD_BITS'(1));

	// 2*prod + bit*a stays below 3m, so at most two subtractions of m
	always_comb begin
		sum    = {1'b0, prod_q, 1'b0}
			+ (mul_b_q[MOD_BITS-1] ? {2'b00, mul_a_q} : SUM_W'(0));
		mod_1x = {2'b00, modulus};
		mod_2x = {1'b0, modulus, 1'b0};
		if (sum >= mod_2x) begin
			step = sum - mod_2x;
		end else if (sum >= mod_1x) begin
			step = sum - mod_1x;
		end else begin
			step = sum;
		end
		next_prod = step[MOD_BITS-1:0];
	end

	assign last_bit = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			to_base_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.load || cmd.start_sqr || cmd.start_mul) begin
				busy_q    <= 1'b1;
				cnt_q     <= CNT_W'(MOD_BITS - 1);
				to_base_q <= cmd.load;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// byte mod m is the product (1 mod m) * byte
			mul_a_q <= one_mod;
			mul_b_q <= MOD_BITS'(in_byte);
			prod_q  <= '0;
			acc_q   <= one_mod;
		end else if (cmd.start_sqr) begin
			mul_a_q <= acc_q;
			mul_b_q <= acc_q;
			prod_q  <= '0;
		end else if (cmd.start_mul) begin
			mul_a_q <= base_q;
			mul_b_q <= acc_q;
			prod_q  <= '0;
		end else if (busy_q) begin
			prod_q  <= next_prod;
			mul_b_q <= {mul_b_q[MOD_BITS-2:0], 1'b0};
			if (last_bit) begin
				if (to_base_q) begin
					base_q <= next_prod;
				end else begin
					acc_q <= next_prod;
				end
			end
		end
		if (cmd.emit) begin
			res_q <= (modulus == '0) ? '0 : acc_q;
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign result      = res_q;

endmodule

[rtl/mexp_ctrl.sv]
// ---------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for left-to-right square-and-multiply over the exponent bits,
// plus the input and output handshakes.
// ---------------------------------------------------------------------------
module mexp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic [mexp_pkg::EXP_BITS-1:0] exponent,
	input  mexp_pkg::mexp_status_t        status,
	output mexp_pkg::mexp_cmd_t           cmd
);
	import mexp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_SQR,
		ST_MUL,
		ST_WB
	} state_t;

	state_t            state_q;
	logic [EBIT_W-1:0] ebit_q;
	logic              start_sqr_q;
	logic              start_mul_q;
	logic              out_valid_q;
	logic              emit;

	assign in_ready = (state_q == ST_IDLE);
	assign emit     = (state_q == ST_WB) && (!out_valid_q || out_ready);

	assign cmd.load      = in_ready && in_valid;
	assign cmd.start_sqr = start_sqr_q;
	assign cmd.start_mul = start_mul_q;
	assign cmd.emit      = emit;
	assign out_valid     = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ebit_q      <= '0;
			start_sqr_q <= 1'b0;
			start_mul_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_sqr_q <= 1'b0;
			start_mul_q <= 1'b0;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (status.done) begin
						ebit_q      <= EBIT_W'(EXP_BITS - 1);
						start_sqr_q <= 1'b1;
						state_q     <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (status.done) begin
						if (exponent[ebit_q]) begin
							start_mul_q <= 1'b1;
							state_q     <= ST_MUL;
						end else if (ebit_q == '0) begin
							state_q <= ST_WB;
						end else begin
							ebit_q      <= ebit_q - EBIT_W'(1);
							start_sqr_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					if (status.done) begin
						if (ebit_q == '0) begin
							state_q <= ST_WB;
						end else begin
							ebit_q      <= ebit_q - EBIT_W'(1);
							start_sqr_q <= 1'b1;
							state_q     <= ST_SQR;
						end
					end
				end
				ST_WB: begin
					// hold until the output register is free
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/modular_exponentiation.sv]
// Each byte costs one modular product for its reduction, one square per exponent bit
// and one multiply per set exponent bit; one byte in flight at a time.
// Each modular product runs as a start, MOD_BITS serial steps and a done.
// The next byte can be taken in the cycle after its result is loaded into the output
// register; a result waits in the output register while the next byte is worked on.
// Reset (arst_n low): exponent = 1, modulus = 1, no result pending, idle.
// ---------------------------------------------------------------------------
// modular_exponentiation
// Byte-wise RSA power: cipher = message_byte ^ exponent mod modulus.
// ---------------------------------------------------------------------------
`include "modular_exponentiation_assert.svh"

module modular_exponentiation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mexp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mexp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mexp_pkg::BYTE_BITS-1:0]  s_tdata,   // [7:0] message_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mexp_pkg::OUT_W-1:0]      m_tdata    // [30:0] cipher_value, rest zero
);
	import mexp_pkg::*;

	logic [EXP_BITS-1:0] exponent_q;
	logic [MOD_BITS-1:0] modulus_q;
	logic [MOD_BITS-1:0] result;
	mexp_cmd_t           cmd;
	mexp_status_t        status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exponent_q <= EXP_BITS'(1);
			modulus_q  <= MOD_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPONENT: exponent_q <= cfg_data[EXP_BITS-1:0];
				REG_MODULUS:  modulus_q  <= cfg_data[MOD_BITS-1:0];
				default: ;
			endcase
		end
	end

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.exponent  (exponent_q),
		.status    (status),
		.cmd       (cmd)
	);

	mexp_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.in_byte (s_tdata),
		.modulus (modulus_q),
		.result  (result)
	);

	assign m_tdata = OUT_W'(result);

	`MEXP_CHECK_NEXT(a_leave_idle, s_tvalid && s_tready, !s_tready,
		"accepted byte did not start work")
	`MEXP_CHECK(a_done_not_idle, status.done || status.busy, !s_tready,
		"multiplier active while idle")
	`MEXP_CHECK(a_result_range, m_tvalid,
		(modulus_q == '0) ? (m_tdata == '0) : (m_tdata < OUT_W'(modulus_q)),
		"result not reduced")

endmodule
